@@ sv/pdb_pkg.sv @@
// shared constants, types and helpers for the polyphase decimator with biquad tail
// no dependencies; imported by polyphase_decimator_biquad
package pdb_pkg;

    localparam int HISTORY_DEPTH  = 8;
    localparam int POS_BITS       = $clog2(HISTORY_DEPTH);
    localparam int NUM_PHASES     = 4;
    localparam int PHASE_BITS     = $clog2(NUM_PHASES);
    localparam int SAMPLE_BITS    = 24;
    localparam int STATE_BITS     = 32;
    localparam int STATE_FRAC     = STATE_BITS - 8;
    localparam int TAP_BITS       = 16;
    localparam int TAP_FRAC       = TAP_BITS - 1;
    localparam int COEF_BITS      = 24;
    localparam int COEF_FRAC      = 20;
    localparam int NUM_PAIRS      = 16;
    localparam int PAIR_BITS      = $clog2(NUM_PAIRS);
    localparam int TAPS_PER_REG   = 4;
    localparam int TAP_SEL_BITS   = $clog2(TAPS_PER_REG);
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;

    // shared multiplier: state or pair sum on port a, coefficient or tap on port b
    localparam int PAIR_SUM_BITS  = SAMPLE_BITS + 1;
    localparam int MUL_A_BITS     = STATE_BITS;
    localparam int MUL_B_BITS     = COEF_BITS + 1;
    localparam int PROD_BITS      = MUL_A_BITS + MUL_B_BITS;
    localparam int ACC_BITS       = PAIR_SUM_BITS + TAP_BITS + PAIR_BITS;
    localparam int FIR_SHIFT      = (SAMPLE_BITS - 1) + TAP_FRAC - STATE_FRAC;
    localparam int RND_BITS       = PROD_BITS - COEF_FRAC;
    localparam int SUM_BITS       = RND_BITS + 2;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_TAPS_LOW      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TAPS_MID_LOW  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TAPS_MID_HIGH = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TAPS_HIGH     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POLE          = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DAMP          = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIX           = 3'd6;

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase_a;
        logic [POS_BITS-1:0]   age_a;
        logic [PHASE_BITS-1:0] phase_b;
        logic [POS_BITS-1:0]   age_b;
    } pair_t;

    // phase and age of the two samples folded onto each tap
    localparam pair_t PAIR_TAB [NUM_PAIRS] = '{
        '{2'd2, 3'd7, 2'd1, 3'd0}, '{2'd3, 3'd7, 2'd0, 3'd0},
        '{2'd2, 3'd0, 2'd1, 3'd7}, '{2'd3, 3'd0, 2'd0, 3'd7},
        '{2'd3, 3'd6, 2'd0, 3'd1}, '{2'd2, 3'd6, 2'd1, 3'd1},
        '{2'd2, 3'd1, 2'd1, 3'd6}, '{2'd3, 3'd1, 2'd0, 3'd6},
        '{2'd3, 3'd5, 2'd0, 3'd2}, '{2'd1, 3'd2, 2'd2, 3'd5},
        '{2'd2, 3'd2, 2'd1, 3'd5}, '{2'd0, 3'd5, 2'd3, 3'd2},
        '{2'd3, 3'd4, 2'd0, 3'd3}, '{2'd2, 3'd4, 2'd1, 3'd3},
        '{2'd2, 3'd3, 2'd1, 3'd4}, '{2'd3, 3'd3, 2'd0, 3'd4}
    };

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [SUM_BITS-1:0] v
    );
        logic [SUM_BITS-STATE_BITS:0] top;
        top = v[SUM_BITS-1:STATE_BITS-1];
        if (&top || ~|top)
            return v[STATE_BITS-1:0];
        else if (v[SUM_BITS-1])
            return {1'b1, {(STATE_BITS-1){1'b0}}};
        else
            return {1'b0, {(STATE_BITS-1){1'b1}}};
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [STATE_BITS-1:0] v
    );
        logic [STATE_BITS-SAMPLE_BITS:0] top;
        top = v[STATE_BITS-1:SAMPLE_BITS-1];
        if (&top || ~|top)
            return v[SAMPLE_BITS-1:0];
        else if (v[STATE_BITS-1])
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

endpackage

@@ sv/polyphase_decimator_biquad.sv @@
// polyphase decimator: folded symmetric 32-sample fir followed by a three-state biquad tail
// one shared multiplier under a step sequencer; depends on pdb_pkg
//
// usage:
//   input channel (in_valid / in_stall) carries four sub-samples and a feedback gain;
//   a word is taken when in_valid is high and in_stall is low. in_stall stays high
//   from the accepting edge until the result has moved into the output register.
//   output channel (out_valid / out_stall) carries one out_sample word per input word.
//   configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready; the user
//   must write it only while the block is idle, which the block itself does not enforce; index 7 is ignored.
// schedule:
//   a new word is not taken until the previous result has left the sequencer. the
//   single 32x25 multiplier runs one tail product, then the sixteen tap products back to
//   back, then five more tail products in dependency order, with a read stage in front
//   and a rounding/saturation stage behind.
// stall:
//   a finished result waits in the sequencer while the output register is full and
//   stalled; the output word holds until taken. the next input word is accepted as soon
//   as the result has moved to the output register.
// reset:
//   rst_n clears the histories (through per-row valid bits), the write position, the
//   biquad state and all configuration registers; no clearing pass is needed.
module polyphase_decimator_biquad (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [pdb_pkg::SAMPLE_BITS-1:0] sub_sample_0,
    input  logic signed [pdb_pkg::SAMPLE_BITS-1:0] sub_sample_1,
    input  logic signed [pdb_pkg::SAMPLE_BITS-1:0] sub_sample_2,
    input  logic signed [pdb_pkg::SAMPLE_BITS-1:0] sub_sample_3,
    input  logic signed [pdb_pkg::COEF_BITS-1:0]   feedback_gain,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pdb_pkg::SAMPLE_BITS-1:0] out_sample,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pdb_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [pdb_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
    import pdb_pkg::*;

    localparam int STEP_BITS = 5;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // sequencer steps; an op issued at one step is in prod_reg during the next step
    localparam logic [STEP_BITS-1:0] S_OP_POLE_OLD = 5'd0;
    localparam logic [STEP_BITS-1:0] S_V521        = 5'd1;
    localparam logic [STEP_BITS-1:0] S_FIR_FIRST   = 5'd1;
    localparam logic [STEP_BITS-1:0] S_FIR_LAST    = 5'd16;
    localparam logic [STEP_BITS-1:0] S_ACC_FIRST   = 5'd2;
    localparam logic [STEP_BITS-1:0] S_ACC_LAST    = 5'd17;
    localparam logic [STEP_BITS-1:0] S_OP_DAMP     = 5'd17;
    localparam logic [STEP_BITS-1:0] S_FIR_OUT     = 5'd18;
    localparam logic [STEP_BITS-1:0] S_V525        = 5'd19;
    localparam logic [STEP_BITS-1:0] S_OP_MIX_FIR  = 5'd19;
    localparam logic [STEP_BITS-1:0] S_M6          = 5'd20;
    localparam logic [STEP_BITS-1:0] S_OP_POLE_NEW = 5'd20;
    localparam logic [STEP_BITS-1:0] S_S2          = 5'd21;
    localparam logic [STEP_BITS-1:0] S_OP_GAIN     = 5'd21;
    localparam logic [STEP_BITS-1:0] S_T           = 5'd22;
    localparam logic [STEP_BITS-1:0] S_OP_MIX_T    = 5'd23;
    localparam logic [STEP_BITS-1:0] S_U           = 5'd24;
    localparam logic [STEP_BITS-1:0] S_Y           = 5'd25;

    logic [1:0]                    state_reg;
    logic [STEP_BITS-1:0]          step_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic [POS_BITS-1:0]           write_pos_reg;
    logic [POS_BITS-1:0]           write_pos_next;
    logic [HISTORY_DEPTH-1:0]      hist_valid_reg;
    logic [NUM_PHASES-1:0]         rd_ok_reg;

    logic [CFG_DATA_BITS-1:0]      taps_reg [NUM_PAIRS/TAPS_PER_REG];
    logic signed [COEF_BITS-1:0]   pole_reg;
    logic signed [COEF_BITS-1:0]   damp_reg;
    logic signed [COEF_BITS-1:0]   mix_reg;
    logic signed [COEF_BITS-1:0]   gain_reg;

    logic signed [STATE_BITS-1:0]  s1_reg;
    logic signed [STATE_BITS-1:0]  s2_reg;
    logic signed [STATE_BITS-1:0]  s3_reg;

    logic signed [SAMPLE_BITS-1:0] hist_mem [NUM_PHASES][HISTORY_DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_reg [NUM_PHASES];
    logic signed [SAMPLE_BITS-1:0] in_sample [NUM_PHASES];
    logic [POS_BITS-1:0]           rd_addr [NUM_PHASES];

    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic signed [STATE_BITS-1:0]  fir_reg;
    logic signed [STATE_BITS-1:0]  v521_reg;
    logic signed [STATE_BITS-1:0]  damp_sum_reg;
    logic signed [STATE_BITS-1:0]  v525_reg;
    logic signed [RND_BITS-1:0]    m6_reg;
    logic signed [STATE_BITS-1:0]  t_reg;
    logic signed [STATE_BITS-1:0]  u_reg;
    logic signed [STATE_BITS-1:0]  y_reg;

    logic                          accept;
    logic                          cfg_write;
    logic                          out_load;
    pair_t                         pair_rd;
    pair_t                         pair_mul;
    logic [PAIR_BITS-1:0]          mul_idx;
    logic signed [SAMPLE_BITS-1:0] smp_a;
    logic signed [SAMPLE_BITS-1:0] smp_b;
    logic signed [PAIR_SUM_BITS-1:0] pair_sum;
    logic signed [TAP_BITS-1:0]    tap_sel;
    logic signed [MUL_A_BITS-1:0]  mul_a;
    logic signed [MUL_B_BITS-1:0]  mul_b;
    logic signed [RND_BITS-1:0]    rnd;
    logic signed [STATE_BITS:0]    y_half;
    logic signed [SAMPLE_BITS-1:0] out_next;

    assign in_sample[0] = sub_sample_0;
    assign in_sample[1] = sub_sample_1;
    assign in_sample[2] = sub_sample_2;
    assign in_sample[3] = sub_sample_3;

    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // histories are written newest-first, so the position steps backwards
    assign write_pos_next = write_pos_reg - POS_BITS'(1);

    // read side: each pair touches two different phases, one address per phase memory
    assign pair_rd = PAIR_TAB[step_reg[PAIR_BITS-1:0]];
    always_comb
    begin
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (pair_rd.phase_a == PHASE_BITS'(p))
                rd_addr[p] = write_pos_reg + pair_rd.age_a;
            else
                rd_addr[p] = write_pos_reg + pair_rd.age_b;
        end
    end

    // multiply side works on the pair read in the previous step
    assign mul_idx  = PAIR_BITS'(step_reg - STEP_BITS'(1));
    assign pair_mul = PAIR_TAB[mul_idx];
    assign smp_a    = rd_ok_reg[pair_mul.phase_a] ? rd_reg[pair_mul.phase_a] : '0;
    assign smp_b    = rd_ok_reg[pair_mul.phase_b] ? rd_reg[pair_mul.phase_b] : '0;
    assign pair_sum = PAIR_SUM_BITS'(smp_a) + PAIR_SUM_BITS'(smp_b);
    assign tap_sel  = $signed(taps_reg[mul_idx[PAIR_BITS-1:TAP_SEL_BITS]]
                              [{mul_idx[TAP_SEL_BITS-1:0], 4'b0000} +: TAP_BITS]);

    always_comb
    begin
        mul_a = s1_reg;
        mul_b = MUL_B_BITS'(pole_reg);
        case (step_reg) inside
            S_OP_POLE_OLD:
            begin
                mul_a = s1_reg;
                mul_b = MUL_B_BITS'(pole_reg);
            end
            [S_FIR_FIRST:S_FIR_LAST]:
            begin
                mul_a = MUL_A_BITS'(pair_sum);
                mul_b = MUL_B_BITS'(tap_sel);
            end
            S_OP_DAMP:
            begin
                mul_a = s1_reg;
                mul_b = MUL_B_BITS'(damp_reg);
            end
            S_OP_MIX_FIR:
            begin
                mul_a = fir_reg;
                mul_b = MUL_B_BITS'(mix_reg);
            end
            S_OP_POLE_NEW:
            begin
                mul_a = v525_reg;
                mul_b = MUL_B_BITS'(pole_reg);
            end
            S_OP_GAIN:
            begin
                mul_a = v525_reg;
                mul_b = MUL_B_BITS'(gain_reg);
            end
            S_OP_MIX_T:
            begin
                mul_a = t_reg;
                mul_b = MUL_B_BITS'(mix_reg);
            end
            default:
            begin
                mul_a = s1_reg;
                mul_b = MUL_B_BITS'(pole_reg);
            end
        endcase
    end

    // product rounded half up back to the state format
    assign rnd = RND_BITS'((prod_reg + (PROD_BITS'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC);

    assign y_half   = (STATE_BITS + 1)'(y_reg) + (STATE_BITS + 1)'(1);
    assign out_next = sat_sample(y_half[STATE_BITS:1]);

    // history memories and the shared multiplier datapath
    always_ff @(posedge clk)
    begin
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (accept)
                hist_mem[p][write_pos_next] <= in_sample[p];
            rd_reg[p] <= hist_mem[p][rd_addr[p]];
        end

        prod_reg <= mul_a * mul_b;

        if (accept)
        begin
            acc_reg  <= '0;
            gain_reg <= feedback_gain;
        end
        else if (state_reg == ST_RUN)
        begin
            if (step_reg >= S_ACC_FIRST && step_reg <= S_ACC_LAST)
                acc_reg <= acc_reg + ACC_BITS'(prod_reg);
            case (step_reg)
                S_V521:
                    v521_reg <= sat_state(SUM_BITS'(rnd) + SUM_BITS'(s3_reg));
                S_FIR_OUT:
                begin
                    fir_reg      <= STATE_BITS'(acc_reg >>> FIR_SHIFT);
                    damp_sum_reg <= sat_state(SUM_BITS'(rnd) + SUM_BITS'(v521_reg));
                end
                S_V525:
                    v525_reg <= sat_state(SUM_BITS'(fir_reg) - SUM_BITS'(damp_sum_reg));
                S_M6:
                    m6_reg <= rnd;
                S_T:
                    t_reg <= sat_state(SUM_BITS'(v521_reg) - SUM_BITS'(rnd));
                S_U:
                    u_reg <= sat_state(SUM_BITS'(rnd) - SUM_BITS'(m6_reg));
                S_Y:
                    y_reg <= sat_state(SUM_BITS'(u_reg) + SUM_BITS'(fir_reg));
                default:
                begin
                end
            endcase
        end

        if (out_load)
            out_sample_reg <= out_next;
    end

    // sequencer, history valid rows, biquad state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            write_pos_reg  <= '0;
            hist_valid_reg <= '0;
            rd_ok_reg      <= '0;
            s1_reg         <= '0;
            s2_reg         <= '0;
            s3_reg         <= '0;
            for (int r = 0; r < NUM_PAIRS / TAPS_PER_REG; r++)
                taps_reg[r] <= '0;
            pole_reg       <= '0;
            damp_reg       <= '0;
            mix_reg        <= '0;
        end
        else
        begin
            for (int p = 0; p < NUM_PHASES; p++)
                rd_ok_reg[p] <= hist_valid_reg[rd_addr[p]];

            if (out_valid_reg && !out_stall && !out_load)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg                      <= ST_RUN;
                        step_reg                       <= '0;
                        write_pos_reg                  <= write_pos_next;
                        hist_valid_reg[write_pos_next] <= 1'b1;
                        // the tail state rotates before any work on the item
                        s3_reg                         <= s1_reg;
                        s1_reg                         <= s2_reg;
                    end
                end
                ST_RUN:
                begin
                    step_reg <= step_reg + STEP_BITS'(1);
                    case (step_reg)
                        S_S2:
                            s2_reg <= sat_state(SUM_BITS'(rnd) + SUM_BITS'(s1_reg));
                        S_T:
                            s1_reg <= v521_reg;
                        S_Y:
                            state_reg <= ST_DONE;
                        default:
                        begin
                        end
                    endcase
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase

            if (cfg_write)
            begin
                case (cfg_index) inside
                    [REG_TAPS_LOW:REG_TAPS_HIGH]:
                        taps_reg[cfg_index[1:0]] <= cfg_data;
                    REG_POLE:
                        pole_reg <= $signed(cfg_data[COEF_BITS-1:0]);
                    REG_DAMP:
                        damp_reg <= $signed(cfg_data[COEF_BITS-1:0]);
                    REG_MIX:
                        mix_reg <= $signed(cfg_data[COEF_BITS-1:0]);
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule
